[hw/rtl/raster_sample_bit_unpacker_macros.svh]
// Assertion macros for the raster sample bit unpacker.
`ifndef RASTER_SAMPLE_BIT_UNPACKER_MACROS_SVH
`define RASTER_SAMPLE_BIT_UNPACKER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RSBU_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define RSBU_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/rsbu_pkg.sv]
// Shared types, constants and helpers for the raster sample bit unpacker.
`timescale 1ns / 1ps

package rsbu_pkg;

   localparam int MAX_DEPTH = 32;
   localparam int ROW_BITS  = 16;

   // depth classes
   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_PACKED = 2'd1;
   localparam logic [1:0] MODE_BYTES  = 2'd2;

   // csr register indexes
   localparam logic [7:0] CSR_SAMPLE_DEPTH = 8'd0;
   localparam logic [7:0] CSR_ROW_BYTES    = 8'd1;

   typedef struct packed {
      logic                has_sample;
      logic                more;
      logic [31:0]         sample;
      logic [5:0]          remain;
   } extract_result_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] row_now;
      logic                row_end;
   } row_status_type;

   function automatic logic [1:0] depth_mode(input logic [5:0] d);
      logic [1:0] m;
      m = MODE_NONE;
      if (d >= 6'd1 && d <= 6'd15 && int'(d) <= MAX_DEPTH) begin
         m = MODE_PACKED;
      end else if ((d == 6'd16 || d == 6'd24 || d == 6'd32) && int'(d) <= MAX_DEPTH) begin
         m = MODE_BYTES;
      end
      return m;
   endfunction

   // ones in the low n bits; all ones from 32 up
   function automatic logic [31:0] low_mask(input logic [5:0] n);
      logic [31:0] m;
      m = n[5] ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << n[4:0]);
      return m;
   endfunction

endpackage

[hw/rtl/raster_sample_bit_unpacker.sv]
// Top level of the raster sample bit unpacker: sequencer, bit holder, result beat.
//
// Usage
//   req channel: one raw image byte per beat (req_data_byte), with req_restart
//   clearing held bits and both row counters before that byte is used.
//   rsp channel: one unpacked sample per beat, right-aligned, tagged with its
//   row, end_of_row on the final sample of the byte that closes a row, and
//   rsp_last on the final sample a byte produced.
//   csr channel: index 0 = sample_depth (write clears held bits), index 1 =
//   row_bytes; csr_ready is always high, other indexes are dropped.
// Timing
//   A byte is taken in the idle state, then the shared extract unit hands out one
//   sample per cycle unless rsp_stall holds the output; a byte that yields no
//   sample still passes through the emit state before the next byte is taken.
//   The first sample is loaded into the output register from the emit state.
//   req_stall is high from after the req beat until the last sample is loaded.
// Stall / reset
//   rsp_stall freezes the output register and the sequencer; the next byte
//   can be taken while the final sample of the last byte still waits.
//   Synchronous reset: depth 8, row_bytes 1, holder and counters cleared.
`timescale 1ns / 1ps
`include "raster_sample_bit_unpacker_macros.svh"

module raster_sample_bit_unpacker
   import rsbu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   // sample output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_sample_value,
   output logic [15:0] rsp_row_index,
   output logic        rsp_end_of_row,
   output logic        rsp_last,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   // config
   logic [5:0]          depth_ff, depth_in;
   logic [15:0]         row_bytes_ff, row_bytes_in;

   // sequencer and holder
   logic                state_ff, state_in;
   logic [31:0]         holder_ff, holder_in;
   logic [5:0]          held_ff, held_in;

   // per-byte row context
   logic [ROW_BITS-1:0] row_ctx_ff, row_ctx_in;
   logic                row_end_ctx_ff, row_end_ctx_in;

   // result beat
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         sample_ff, sample_in;
   logic [15:0]         row_index_ff, row_index_in;
   logic                eor_ff, eor_in;
   logic                last_ff, last_in;

   logic [1:0]          mode;
   logic                req_beat;
   logic                csr_wr;
   logic                slot_free;
   logic [31:0]         base_holder, merge_holder;
   logic [5:0]          base_held, merge_held;
   extract_result_type  ex;
   row_status_type      row_status;

   assign mode      = depth_mode(depth_ff);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   rsbu_row_track u_row_track (
      .clock     (clock),
      .reset     (reset),
      .step      (req_beat),
      .restart   (req_restart),
      .row_bytes (row_bytes_ff),
      .status    (row_status)
   );

   rsbu_extract u_extract (
      .holder (holder_ff),
      .held   (held_ff),
      .depth  (depth_ff),
      .mode   (mode),
      .result (ex)
   );

   // fold the incoming byte into the holder
   always_comb begin
      base_holder  = req_restart ? 32'd0 : holder_ff;
      base_held    = req_restart ? 6'd0 : held_ff;
      merge_holder = 32'd0;
      merge_held   = 6'd0;
      case (mode)
         MODE_PACKED: begin
            merge_holder = {base_holder[23:0], req_data_byte};
            merge_held   = base_held + 6'd8;
         end
         MODE_BYTES: begin
            if (base_held >= 6'd32) begin
               base_holder = 32'd0;
               base_held   = 6'd0;
            end
            // first byte lands lowest
            merge_holder = base_holder | ({24'd0, req_data_byte} << base_held[4:0]);
            merge_held   = base_held + 6'd8;
         end
         default: begin
            merge_holder = 32'd0;
            merge_held   = 6'd0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      holder_in      = holder_ff;
      held_in        = held_ff;
      row_ctx_in     = row_ctx_ff;
      row_end_ctx_in = row_end_ctx_ff;
      depth_in       = depth_ff;
      row_bytes_in   = row_bytes_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      sample_in      = sample_ff;
      row_index_in   = row_index_ff;
      eor_in         = eor_ff;
      last_in        = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               holder_in      = merge_holder;
               held_in        = merge_held;
               row_ctx_in     = row_status.row_now;
               row_end_ctx_in = row_status.row_end;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!ex.has_sample) begin
               // nothing (more) to hand out: close the byte
               if (row_end_ctx_ff) begin
                  holder_in = 32'd0;
                  held_in   = 6'd0;
               end else begin
                  holder_in = holder_ff & low_mask(held_ff);
               end
               state_in = ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               sample_in    = ex.sample;
               row_index_in = 16'(row_ctx_ff);
               last_in      = !ex.more;
               eor_in       = !ex.more && row_end_ctx_ff;
               held_in      = ex.remain;
               if (!ex.more) begin
                  // padding bits die at a row end
                  if (row_end_ctx_ff) begin
                     holder_in = 32'd0;
                     held_in   = 6'd0;
                  end else begin
                     holder_in = holder_ff & low_mask(ex.remain);
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr) begin
         unique case (csr_index)
            CSR_SAMPLE_DEPTH: begin
               depth_in  = csr_data[5:0];
               holder_in = 32'd0;
               held_in   = 6'd0;
            end
            CSR_ROW_BYTES: begin
               row_bytes_in = csr_data;
            end
            default: begin
               depth_in = depth_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= 6'd8;
         row_bytes_ff <= 16'd1;
         holder_ff    <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         row_bytes_ff <= row_bytes_in;
         holder_ff    <= holder_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ctx_ff     <= row_ctx_in;
      row_end_ctx_ff <= row_end_ctx_in;
      sample_ff      <= sample_in;
      row_index_ff   <= row_index_in;
      eor_ff         <= eor_in;
      last_ff        <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = sample_ff;
   assign rsp_row_index    = row_index_ff;
   assign rsp_end_of_row   = eor_ff;
   assign rsp_last         = last_ff;

   // between bytes a packed holder never keeps a whole sample back
   `RSBU_ASSERT_IMPL(a_idle_no_pending, (state_ff == ST_IDLE) && (mode == MODE_PACKED), held_ff < depth_ff, "packed sample left in holder while idle")
   // holder count stays within one word
   `RSBU_ASSERT_IMPL(a_held_bound, 1'b1, held_ff <= 6'd32, "bit count beyond holder width")
   // a row closes only on the final sample of a byte
   `RSBU_ASSERT_IMPL(a_eor_is_last, rsp_valid && rsp_end_of_row, rsp_last, "end_of_row without last")
   // once a byte is taken the sequencer is busy the next cycle
   `RSBU_ASSERT_NEXT(a_busy_after_beat, req_beat, req_stall, "req taken while a byte is in work")

endmodule

[hw/rtl/rsbu_extract.sv]
// Shared shift-and-compare unit: pulls one sample out of the bit holder.
`timescale 1ns / 1ps

module rsbu_extract
   import rsbu_pkg::*;
(
   input  logic [31:0]        holder,
   input  logic [5:0]         held,
   input  logic [5:0]         depth,
   input  logic [1:0]         mode,
   output extract_result_type result
);

   logic [5:0] remain;

   assign remain = held - depth;

   always_comb begin
      result = '0;
      case (mode)
         MODE_PACKED: begin
            result.has_sample = (held >= depth);
            result.remain     = remain;
            result.more       = (remain >= depth);
            result.sample     = (holder >> remain) & low_mask(depth);
         end
         MODE_BYTES: begin
            // whole word leaves at once
            result.has_sample = (held >= depth);
            result.remain     = 6'd0;
            result.more       = 1'b0;
            result.sample     = holder;
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

[hw/rtl/rsbu_row_track.sv]
// Byte-in-row and row counters.
`timescale 1ns / 1ps

module rsbu_row_track
   import rsbu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic           restart,
   input  logic [15:0]    row_bytes,
   output row_status_type status
);

   logic [15:0]         byte_in_row_ff, byte_in_row_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [15:0]         bir_next;
   logic [ROW_BITS-1:0] row_base;

   always_comb begin
      bir_next       = (restart ? 16'd0 : byte_in_row_ff) + 16'd1;
      row_base       = restart ? '0 : row_ff;
      // zero row length acts as one: compare is always true
      status.row_end = (bir_next >= row_bytes);
      status.row_now = row_base;
      byte_in_row_in = byte_in_row_ff;
      row_in         = row_ff;
      if (step) begin
         byte_in_row_in = status.row_end ? 16'd0 : bir_next;
         row_in         = status.row_end ? row_base + ROW_BITS'(1) : row_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_in_row_ff <= '0;
         row_ff         <= '0;
      end else begin
         byte_in_row_ff <= byte_in_row_in;
         row_ff         <= row_in;
      end
   end

endmodule

[verif/raster_sample_bit_unpacker_tb.sv]
// Self-checking testbench for the raster sample bit unpacker, with its sample predictor.
`timescale 1ns / 1ps

module raster_sample_bit_unpacker_tb;
   import rsbu_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 12;   // no-sample byte still in flight after last beat
   localparam int HOLD_CYCLES   = 400;  // one long rsp hold-off to back the block up
   localparam int IDLE_PCT      = 23;
   localparam logic [7:0] CSR_INDEX_TOP = 8'hFF;   // past the register list, ignored

   // Predicts the sample beats from accepted bytes and checks them in order.
   class sample_tracker;
      typedef struct {
         logic [31:0] value;
         logic [15:0] row;
         logic        row_end;
         logic        last;
      } sample_beat_type;

      logic [5:0]      depth;
      logic [15:0]     row_len;
      logic [31:0]     holder;
      int unsigned     held;
      logic [15:0]     byte_count;
      logic [15:0]     row_count;
      sample_beat_type due_samples[$];
      int unsigned     mismatches;

      function new();
         depth       = 6'd8;
         row_len     = 16'd1;
         holder      = '0;
         held        = 0;
         byte_count  = '0;
         row_count   = '0;
         mismatches  = 0;
      endfunction

      function void apply_reg(input logic [7:0] reg_index, input logic [15:0] data);
         if (reg_index == CSR_SAMPLE_DEPTH) begin
            depth  = data[5:0];
            holder = '0;
            held   = 0;
         end else if (reg_index == CSR_ROW_BYTES) begin
            row_len = data;
         end
      endfunction

      function void take_byte(input logic [7:0] b, input logic restart);
         logic [31:0]     found[$];
         sample_beat_type beat;
         logic [15:0]     row_was;
         logic            closes;
         if (restart) begin
            holder     = '0;
            held       = 0;
            byte_count = '0;
            row_count  = '0;
         end
         if (depth >= 6'd1 && depth <= 6'd15) begin
            // MSB-first packing, samples may straddle bytes
            holder = (holder << 8) | {24'd0, b};
            held   = held + 8;
            while (held >= depth && found.size() < 8) begin
               held  = held - depth;
               found = {found, (holder >> held) & ((32'd1 << depth) - 32'd1)};
            end
            holder = holder & ((32'd1 << held) - 32'd1);
         end else if (depth == 6'd16 || depth == 6'd24 || depth == 6'd32) begin
            // whole bytes, first byte lowest
            if (held >= 32) begin
               holder = '0;
               held   = 0;
            end
            holder = holder | ({24'd0, b} << held);
            held   = held + 8;
            if (held >= depth) begin
               found  = {found, holder};
               holder = '0;
               held   = 0;
            end
         end else begin
            holder = '0;
            held   = 0;
         end
         row_was    = row_count;
         byte_count = byte_count + 16'd1;
         closes     = (byte_count >= row_len);
         if (closes) begin
            // padding bits at row end are dropped
            byte_count = '0;
            row_count  = row_count + 16'd1;
            holder     = '0;
            held       = 0;
         end
         foreach (found[k]) begin
            beat.value   = found[k];
            beat.row     = row_was;
            beat.last    = (k == found.size() - 1);
            beat.row_end = beat.last && closes;
            due_samples  = {due_samples, beat};
         end
      endfunction

      function void check_sample(input logic [31:0] value, input logic [15:0] row,
                                 input logic row_end, input logic last);
         sample_beat_type want;
         if (due_samples.size() == 0) begin
            $display("%0t: unexpected sample expected none actual %h row %0d",
                     $time, value, row);
            mismatches++;
            return;
         end
         want = due_samples.pop_front();
         if (value !== want.value) begin
            $display("%0t: sample_value expected %h actual %h", $time, want.value, value);
            mismatches++;
         end
         if (row !== want.row) begin
            $display("%0t: row_index expected %0d actual %0d", $time, want.row, row);
            mismatches++;
         end
         if (row_end !== want.row_end) begin
            $display("%0t: end_of_row expected %b actual %b", $time, want.row_end, row_end);
            mismatches++;
         end
         if (last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_restart;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_sample_value;
   logic [15:0] rsp_row_index;
   logic        rsp_end_of_row;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [15:0] csr_data;

   // idling on/off and the pressure window, driven by the stimulus process only
   logic        idle_on;
   logic        pressure_phase;

   sample_tracker sb = new();
   int          cycle_count = 0;
   int          hold_left   = 0;
   bit          hold_done   = 1'b0;

   raster_sample_bit_unpacker dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_value (rsp_sample_value),
      .rsp_row_index    (rsp_row_index),
      .rsp_end_of_row   (rsp_end_of_row),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Sample side: check each beat against the oldest prediction, then pick next stall.
   // The one long hold-off is counted here, while the sender keeps offering bytes.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_sample(rsp_sample_value, rsp_row_index, rsp_end_of_row, rsp_last);
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (pressure_phase && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Offer one byte beat, wait for acceptance, then maybe leave a gap.
   // Valid stays high on return when no gap follows, so back-to-back beats
   // never see valid lowered and raised in the same step.
   task automatic send_byte(input logic [7:0] b, input logic restart);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_restart   <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_byte(b, restart);
      if (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (idle_on && $urandom_range(99) < IDLE_PCT);
      end
   endtask

   // Drain: all predicted samples out, then let a trailing no-sample byte finish.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.due_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, only with the block idle.
   task automatic write_reg(input logic [7:0] reg_index, input logic [15:0] data);
      settle();
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.apply_reg(reg_index, data);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int          pick;
      logic [5:0]  depth_pick;
      logic [15:0] csr_word;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data_byte  <= '0;
      req_restart    <= 1'b0;
      csr_valid      <= 1'b0;
      csr_index      <= '0;
      csr_data       <= '0;
      idle_on        <= 1'b1;
      pressure_phase <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // reset setting: depth 8, one byte per row
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      // depth 1: eight samples per byte, row closes on the third byte
      write_reg(CSR_SAMPLE_DEPTH, 16'd1);
      write_reg(CSR_ROW_BYTES, 16'd3);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);

      // depth 12: samples straddle bytes
      write_reg(CSR_SAMPLE_DEPTH, 16'd12);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);

      // depth 16: third byte ends the row with nothing emitted, its bits dropped
      write_reg(CSR_SAMPLE_DEPTH, 16'd16);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b0);

      write_reg(CSR_SAMPLE_DEPTH, 16'd24);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hAA, 1'b0);

      // depth 32 with the longest row, then a zero row length
      write_reg(CSR_SAMPLE_DEPTH, 16'd32);
      write_reg(CSR_ROW_BYTES, 16'hFFFF);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      write_reg(CSR_ROW_BYTES, 16'd0);
      send_byte(8'h3C, 1'b0);

      // unsupported depths; upper data bits must be ignored
      write_reg(CSR_SAMPLE_DEPTH, 16'hFFD1);
      send_byte(8'h5A, 1'b0);
      write_reg(CSR_SAMPLE_DEPTH, 16'h003F);
      send_byte(8'hC3, 1'b0);

      // depth change drops held bits, row counters kept
      write_reg(CSR_ROW_BYTES, 16'd100);
      write_reg(CSR_SAMPLE_DEPTH, 16'd12);
      send_byte(8'h9E, 1'b0);
      write_reg(CSR_SAMPLE_DEPTH, 16'hFFC4);
      send_byte(8'h6B, 1'b0);

      // restart in the middle of a straddling sample
      write_reg(CSR_SAMPLE_DEPTH, 16'd12);
      send_byte(8'hAB, 1'b0);
      send_byte(8'hCD, 1'b1);
      send_byte(8'hEF, 1'b0);

      // write past the register list: no effect
      write_reg(CSR_INDEX_TOP, 16'h0005);
      send_byte(8'h77, 1'b0);

      // --- random phases ---
      // each phase: new depth and row length, then a stream of bytes with
      // occasional restarts; phase 3 backs the block up, phase 5 runs flat out
      for (int ph = 0; ph < 9; ph++) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            depth_pick = 6'($urandom_range(1, 15));
         end else if (pick < 85) begin
            depth_pick = 6'(8 * $urandom_range(2, 4));
         end else begin
            depth_pick = 6'($urandom_range(0, 63));
         end
         csr_word      = 16'($urandom());
         csr_word[5:0] = depth_pick;
         write_reg(CSR_SAMPLE_DEPTH, csr_word);

         pick = $urandom_range(99);
         if (pick < 75) begin
            csr_word = 16'($urandom_range(1, 12));
         end else if (pick < 85) begin
            csr_word = 16'd0;
         end else begin
            csr_word = 16'($urandom());
         end
         write_reg(CSR_ROW_BYTES, csr_word);

         if ($urandom_range(3) == 0) begin
            write_reg(8'($urandom_range(2, 255)), 16'($urandom()));
         end

         idle_on        <= (ph != 5);
         pressure_phase <= (ph == 3);
         for (int i = 0; i < 22; i++) begin
            send_byte(8'($urandom()),
                      (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 4));
         end
      end
      idle_on        <= 1'b1;
      pressure_phase <= 1'b0;

      settle();
      if (sb.mismatches == 0 && sb.due_samples.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rsbu_pkg.sv
hw/rtl/rsbu_extract.sv
hw/rtl/rsbu_row_track.sv
hw/rtl/raster_sample_bit_unpacker.sv
verif/raster_sample_bit_unpacker_tb.sv
